>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is held
`define ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, quiet while reset is held
`define ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is checked through reset as well
`define ASSERT_NXT_ALL(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/dbd_pkg.sv
// ----------------------------------------------------------------------------
// dbd_pkg
// Types, constants and calendar tables for the days-between-dates pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package dbd_pkg;

  localparam int YearW  = 14;
  localparam int MonthW = 4;
  localparam int DayW   = 5;
  localparam int CountW = 22;
  localparam int ProdW  = 32;

  localparam logic [YearW-1:0] YEAR_MAX = 14'd9999;

  // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x < 16384
  localparam logic [17:0] RECIP_100   = 18'd167773;
  localparam int          RECIP_SHIFT = 24;

  localparam logic [MonthW-1:0] MONTH_FEB = 4'd2;
  localparam logic [MonthW-1:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic [YearW-1:0]  start_year;
    logic [MonthW-1:0] start_month;
    logic [DayW-1:0]   start_day;
    logic [YearW-1:0]  end_year;
    logic [MonthW-1:0] end_month;
    logic [DayW-1:0]   end_day;
    logic              count_end_day;
  } in_t;

  typedef struct packed {
    logic [CountW-1:0] day_count;
    logic              date_error;
  } out_t;

  // Length of a month in a common year; nonsense months read as zero
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in a common year before the first of the month
  function automatic logic [8:0] days_before(input logic [MonthW-1:0] m);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

>>> design/days_between_dates.sv
// ----------------------------------------------------------------------------
// days_between_dates
// Days from a start date to an end date in the proleptic Gregorian calendar.
// ----------------------------------------------------------------------------
// Input word: two dates (year, month, day) and count_end_day. Output word:
// day_count and date_error. Both sides use valid/ready; a word moves on a
// cycle where valid and ready are both high.
// Each date becomes a serial day number in closed form; the count is the
// difference of the two (zero when start is not before end), plus one when
// count_end_day is set. An invalid date gives date_error = 1 and a count of 0.
// Five register stages: input, divide-by-100 product, year base with leap
// flag, serial day with validity, output; an accepted word moves through
// them in that order to out_valid. One word is taken every cycle while the
// output is not stalled, with one 14x18 multiplier per date in stage two.
// Each stage's ready is its own valid clear or the next stage ready, so
// empty stages fill while the output is stalled; with the output register
// full and out_ready low, in_ready falls only once all five stages hold
// words. Nothing is dropped or repeated under stall.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers
// are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module days_between_dates (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire dbd_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output dbd_pkg::out_t      out_data
);

  // stage valid bits and ready chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !v5_r || out_ready;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // stage 1: capture the input word
  dbd_pkg::in_t in_r;

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      in_r <= in_data;
    end
  end

  // stage 2: previous year and its reciprocal product, range checks
  logic [dbd_pkg::YearW-1:0]  yr    [2];
  logic [dbd_pkg::MonthW-1:0] mo    [2];
  logic [dbd_pkg::DayW-1:0]   dy    [2];
  logic [dbd_pkg::YearW-1:0]  py_nxt[2];
  logic [dbd_pkg::ProdW-1:0]  prod_nxt[2];
  logic                       rng_nxt[2];

  logic [dbd_pkg::YearW-1:0]  py2_r  [2];
  logic [dbd_pkg::ProdW-1:0]  prod2_r[2];
  logic [dbd_pkg::MonthW-1:0] mo2_r  [2];
  logic [dbd_pkg::DayW-1:0]   dy2_r  [2];
  logic                       rng2_r [2];
  logic                       inc2_r;

  assign yr[0] = in_r.start_year;
  assign yr[1] = in_r.end_year;
  assign mo[0] = in_r.start_month;
  assign mo[1] = in_r.end_month;
  assign dy[0] = in_r.start_day;
  assign dy[1] = in_r.end_day;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      py_nxt[i]   = yr[i] - 14'd1;
      prod_nxt[i] = dbd_pkg::ProdW'(py_nxt[i]) * dbd_pkg::ProdW'(dbd_pkg::RECIP_100);
      rng_nxt[i]  = (yr[i] != '0) && (yr[i] <= dbd_pkg::YEAR_MAX) &&
                    (mo[i] != '0) && (mo[i] <= dbd_pkg::MONTH_DEC) && (dy[i] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      for (int i = 0; i < 2; i++) begin
        py2_r[i]   <= py_nxt[i];
        prod2_r[i] <= prod_nxt[i];
        mo2_r[i]   <= mo[i];
        dy2_r[i]   <= dy[i];
        rng2_r[i]  <= rng_nxt[i];
      end
      inc2_r <= in_r.count_end_day;
    end
  end

  // stage 3: leap flag and day count up to the start of the year
  logic [6:0]                 q100  [2];
  logic [6:0]                 r100  [2];
  logic                       leap_nxt[2];
  logic [dbd_pkg::CountW-1:0] base_nxt[2];

  logic [dbd_pkg::CountW-1:0] base3_r[2];
  logic                       leap3_r[2];
  logic [dbd_pkg::MonthW-1:0] mo3_r  [2];
  logic [dbd_pkg::DayW-1:0]   dy3_r  [2];
  logic                       rng3_r [2];
  logic                       inc3_r;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      q100[i] = prod2_r[i][dbd_pkg::RECIP_SHIFT +: 7];
      r100[i] = 7'(py2_r[i] - 14'(q100[i]) * 14'd100);
      // year = py + 1: divisible by 4 when py % 4 is 3, by 100 when py % 100 is 99
      leap_nxt[i] = (py2_r[i][1:0] == 2'b11) &&
                    ((r100[i] != 7'd99) || (q100[i][1:0] == 2'b11));
      base_nxt[i] = dbd_pkg::CountW'(py2_r[i]) * 22'd365
                  + dbd_pkg::CountW'(py2_r[i] >> 2)
                  - dbd_pkg::CountW'(q100[i])
                  + dbd_pkg::CountW'(q100[i] >> 2);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      for (int i = 0; i < 2; i++) begin
        base3_r[i] <= base_nxt[i];
        leap3_r[i] <= leap_nxt[i];
        mo3_r[i]   <= mo2_r[i];
        dy3_r[i]   <= dy2_r[i];
        rng3_r[i]  <= rng2_r[i];
      end
      inc3_r <= inc2_r;
    end
  end

  // stage 4: serial day number and full date check
  logic [dbd_pkg::DayW-1:0]   mlen  [2];
  logic                       ok_nxt[2];
  logic [dbd_pkg::CountW-1:0] ser_nxt[2];

  logic [dbd_pkg::CountW-1:0] ser4_r[2];
  logic                       err4_r;
  logic                       inc4_r;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      mlen[i] = dbd_pkg::month_len(mo3_r[i]);
      if ((mo3_r[i] == dbd_pkg::MONTH_FEB) && leap3_r[i]) begin
        mlen[i] = 5'd29;
      end
      ok_nxt[i]  = rng3_r[i] && (dy3_r[i] <= mlen[i]);
      ser_nxt[i] = base3_r[i]
                 + dbd_pkg::CountW'(dbd_pkg::days_before(mo3_r[i]))
                 + dbd_pkg::CountW'(leap3_r[i] && (mo3_r[i] > dbd_pkg::MONTH_FEB))
                 + dbd_pkg::CountW'(dy3_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      ser4_r[0] <= ser_nxt[0];
      ser4_r[1] <= ser_nxt[1];
      err4_r    <= !(ok_nxt[0] && ok_nxt[1]);
      inc4_r    <= inc3_r;
    end
  end

  // stage 5: difference, clamp at zero, add the end day
  dbd_pkg::out_t out_nxt;
  dbd_pkg::out_t out_r;

  always_comb begin
    out_nxt.date_error = err4_r;
    if (err4_r) begin
      out_nxt.day_count = '0;
    end else if (ser4_r[0] < ser4_r[1]) begin
      out_nxt.day_count = ser4_r[1] - ser4_r[0] + dbd_pkg::CountW'(inc4_r);
    end else begin
      out_nxt.day_count = dbd_pkg::CountW'(inc4_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && v4_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

>>> design/dbd_checker.sv
// ----------------------------------------------------------------------------
// dbd_checker
// Port-level checks on the days-between-dates pipeline, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dbd_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire dbd_pkg::out_t out_data
);

  // a stalled result word holds
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // back-pressure reaches the input only from a full output register
  `ASSERT_IMP(a_ready_only_stalled, clk, rst_n, !in_ready, out_valid && !out_ready)

  // an invalid date always reports a zero count
  `ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && out_data.date_error, out_data.day_count == '0)

  // reset empties the pipeline
  `ASSERT_NXT_ALL(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind days_between_dates dbd_checker u_dbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
